// ===== hdl/rfpe_pkg.sv =====
// shared types and constants of the rotated framebuffer pixel engine
package rfpe_pkg;

   localparam int DEF_PANEL_WIDTH  = 176;
   localparam int DEF_PANEL_HEIGHT = 264;

   // job fields sized for the largest panel the engine supports (512 x 512)
   localparam int JOB_ADDR_W      = 15;
   localparam int JOB_CNT_W       = 7;
   localparam int JOB_QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] REG_ROTATION = '0;

   localparam logic [7:0] FILL_BLACK = 8'h00;
   localparam logic [7:0] FILL_WHITE = 8'hFF;

   typedef enum logic [1:0] {
      CMD_DRAW = 2'd0,
      CMD_FILL = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rotation_type;

   typedef enum logic [1:0] {
      OP_DRAW,
      OP_FILL,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type                op;
      logic                  color;
      logic [2:0]            bit_sel;
      logic [JOB_ADDR_W-1:0] addr;
      logic [JOB_CNT_W-1:0]  count;
   } job_type;

endpackage

// ===== hdl/rfpe_if.sv =====
// request and response channel interfaces
interface rfpe_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic signed [9:0] x;
   logic signed [9:0] y;
   logic              color;
   logic [8:0]        window_width;
   logic [8:0]        window_height;
   logic [8:0]        row_offset;

   modport source (
      output valid, cmd, x, y, color, window_width, window_height, row_offset,
      input  ready
   );
   modport sink (
      input  valid, cmd, x, y, color, window_width, window_height, row_offset,
      output ready
   );
endinterface

interface rfpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   logic       last;

   modport source (output valid, pixel_byte, last, input ready);
   modport sink (input valid, pixel_byte, last, output ready);
endinterface

// ===== hdl/rfpe_front.sv =====
// front end: takes request items, clips and rotates them into store jobs
module rfpe_front #(
   parameter int PANEL_WIDTH  = rfpe_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = rfpe_pkg::DEF_PANEL_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        rotation,
   rfpe_req_if.sink          req,
   output logic              job_valid,
   input  logic              job_ready,
   output rfpe_pkg::job_type job
);

   localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
   localparam int STORE_DEPTH = ROW_BYTES * PANEL_HEIGHT;
   localparam int COL_W       = $clog2(PANEL_WIDTH);
   localparam int ROW_W       = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [10:0] W11 = 11'(PANEL_WIDTH);
   localparam logic [10:0] H11 = 11'(PANEL_HEIGHT);

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_MAP,
      FR_ADDR
   } state_type;

   state_type                         state_ff;
   rfpe_pkg::cmd_type                 cmd_ff;
   logic signed [9:0]                 x_ff;
   logic signed [9:0]                 y_ff;
   logic                              color_ff;
   logic [8:0]                        ww_ff;
   logic [8:0]                        wh_ff;
   logic [8:0]                        roff_ff;
   rfpe_pkg::op_type                  op_ff;
   logic [ROW_W-1:0]                  row_ff;
   logic [COL_W-1:0]                  pix_ff;
   logic [rfpe_pkg::JOB_CNT_W-1:0]    count_ff;

   logic [10:0] xz, yz, lw, lh, px, py;
   logic [10:0] room, wext, wclip, w2, hroom, wh_ext, h2, rrow;
   logic [7:0]  rcount;
   logic        draw_ok, read_ok;
   logic [ADDR_W-1:0] addr_full;

   // bounds, rotation and window clipping
   always_comb begin
      xz     = {1'b0, x_ff};
      yz     = {1'b0, y_ff};
      lw     = rotation[0] ? H11 : W11;
      lh     = rotation[0] ? W11 : H11;
      draw_ok = !x_ff[9] && !y_ff[9] && (xz < lw) && (yz < lh);
      case (rfpe_pkg::rotation_type'(rotation))
         rfpe_pkg::ROT_90: begin
            px = W11 - 11'd1 - yz;
            py = xz;
         end
         rfpe_pkg::ROT_180: begin
            px = W11 - 11'd1 - xz;
            py = H11 - 11'd1 - yz;
         end
         rfpe_pkg::ROT_270: begin
            px = yz;
            py = H11 - 11'd1 - xz;
         end
         default: begin
            px = xz;
            py = yz;
         end
      endcase
      room   = W11 - xz;
      wext   = {2'b00, ww_ff} + 11'd7;
      wclip  = (wext < room) ? wext : room;
      w2     = wclip + {8'b0, x_ff[2:0]};
      rcount = w2[10:3];
      hroom  = H11 - yz;
      wh_ext = {2'b00, wh_ff};
      h2     = (wh_ext < hroom) ? wh_ext : hroom;
      rrow   = yz + {2'b00, roff_ff};
      read_ok = !x_ff[9] && !y_ff[9] && (xz < W11) && (yz < H11)
                && ({2'b00, roff_ff} < h2) && (rcount != 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         case (state_ff)
            FR_IDLE: begin
               if (req.valid) begin
                  cmd_ff   <= rfpe_pkg::cmd_type'(req.cmd);
                  x_ff     <= req.x;
                  y_ff     <= req.y;
                  color_ff <= req.color;
                  ww_ff    <= req.window_width;
                  wh_ff    <= req.window_height;
                  roff_ff  <= req.row_offset;
                  state_ff <= FR_MAP;
               end
            end
            FR_MAP: begin
               case (cmd_ff)
                  rfpe_pkg::CMD_DRAW: begin
                     op_ff    <= rfpe_pkg::OP_DRAW;
                     row_ff   <= py[ROW_W-1:0];
                     pix_ff   <= px[COL_W-1:0];
                     count_ff <= rfpe_pkg::JOB_CNT_W'(1);
                     state_ff <= draw_ok ? FR_ADDR : FR_IDLE;
                  end
                  rfpe_pkg::CMD_FILL: begin
                     op_ff    <= rfpe_pkg::OP_FILL;
                     row_ff   <= '0;
                     pix_ff   <= '0;
                     count_ff <= '0;
                     state_ff <= FR_ADDR;
                  end
                  rfpe_pkg::CMD_READ: begin
                     op_ff    <= rfpe_pkg::OP_READ;
                     row_ff   <= rrow[ROW_W-1:0];
                     pix_ff   <= xz[COL_W-1:0];
                     count_ff <= rcount[rfpe_pkg::JOB_CNT_W-1:0];
                     state_ff <= read_ok ? FR_ADDR : FR_IDLE;
                  end
                  default: begin
                     state_ff <= FR_IDLE;
                  end
               endcase
            end
            FR_ADDR: begin
               if (job_ready) begin
                  state_ff <= FR_IDLE;
               end
            end
            default: begin
               state_ff <= FR_IDLE;
            end
         endcase
      end
   end

   // byte address of the first store byte
   always_comb begin
      addr_full   = ADDR_W'(row_ff) * ADDR_W'(ROW_BYTES) + ADDR_W'(pix_ff >> 3);
      job.op      = op_ff;
      job.color   = color_ff;
      job.bit_sel = pix_ff[2:0];
      job.addr    = rfpe_pkg::JOB_ADDR_W'(addr_full);
      job.count   = count_ff;
   end

   assign req.ready = (state_ff == FR_IDLE);
   assign job_valid = (state_ff == FR_ADDR);

endmodule

// ===== hdl/rfpe_queue.sv =====
// short job queue between the front end and the store sequencer
module rfpe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rfpe_pkg::job_type in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output rfpe_pkg::job_type out_job
);

   localparam int DEPTH  = rfpe_pkg::JOB_QUEUE_DEPTH;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   rfpe_pkg::job_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic               push, pop;

   assign in_ready  = (fill_ff != FILL_W'(DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_job   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         fill_ff <= fill_ff + FILL_W'(push) - FILL_W'(pop);
      end
   end

endmodule

// ===== hdl/rfpe_back.sv =====
// back end: frame store, fill sweep, pixel read-modify-write and row readout
module rfpe_back #(
   parameter int PANEL_WIDTH  = rfpe_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = rfpe_pkg::DEF_PANEL_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  rfpe_pkg::job_type job,
   rfpe_rsp_if.source        rsp
);

   localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
   localparam int STORE_DEPTH = ROW_BYTES * PANEL_HEIGHT;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FILL,
      BK_DRAW_RD,
      BK_DRAW_WR,
      BK_READ
   } state_type;

   state_type                       state_ff;
   logic [ADDR_W-1:0]               addr_ff;
   logic [rfpe_pkg::JOB_CNT_W-1:0]  left_ff;
   logic                            color_ff;
   logic [7:0]                      mask_ff;

   logic [7:0] store_mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;
   logic       rd_last_ff;
   logic       inflight_ff;

   logic [7:0] oq_data_ff [2];
   logic       oq_last_ff [2];
   logic       oq_head_ff;
   logic [1:0] occ_ff;

   logic       pop, can_issue, issue, rd_en, mem_we, tail;
   logic [7:0] mem_wdata;

   assign pop       = rsp.valid && rsp.ready;
   assign can_issue = ({1'b0, occ_ff} + {2'b00, inflight_ff}) < (3'd2 + {2'b00, pop});
   assign issue     = (state_ff == BK_READ) && can_issue;
   assign rd_en     = issue || (state_ff == BK_DRAW_RD);
   assign mem_we    = (state_ff == BK_FILL) || (state_ff == BK_DRAW_WR);
   assign job_ready = (state_ff == BK_IDLE);
   assign tail      = oq_head_ff ^ occ_ff[0];

   always_comb begin
      if (state_ff == BK_FILL) begin
         mem_wdata = color_ff ? rfpe_pkg::FILL_BLACK : rfpe_pkg::FILL_WHITE;
      end else begin
         mem_wdata = color_ff ? (rd_data_ff & ~mask_ff) : (rd_data_ff | mask_ff);
      end
   end

   // frame store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[addr_ff] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[addr_ff];
         rd_last_ff <= (left_ff == rfpe_pkg::JOB_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         case (state_ff)
            BK_IDLE: begin
               if (job_valid) begin
                  addr_ff  <= job.addr[ADDR_W-1:0];
                  left_ff  <= job.count;
                  color_ff <= job.color;
                  mask_ff  <= 8'h80 >> job.bit_sel;
                  case (job.op)
                     rfpe_pkg::OP_FILL: state_ff <= BK_FILL;
                     rfpe_pkg::OP_DRAW: state_ff <= BK_DRAW_RD;
                     rfpe_pkg::OP_READ: state_ff <= BK_READ;
                     default:           state_ff <= BK_IDLE;
                  endcase
               end
            end
            BK_FILL: begin
               addr_ff <= addr_ff + ADDR_W'(1);
               if (addr_ff == LAST_ADDR) begin
                  state_ff <= BK_IDLE;
               end
            end
            BK_DRAW_RD: begin
               state_ff <= BK_DRAW_WR;
            end
            BK_DRAW_WR: begin
               state_ff <= BK_IDLE;
            end
            BK_READ: begin
               if (can_issue) begin
                  addr_ff <= addr_ff + ADDR_W'(1);
                  left_ff <= left_ff - rfpe_pkg::JOB_CNT_W'(1);
                  if (left_ff == rfpe_pkg::JOB_CNT_W'(1)) begin
                     state_ff <= BK_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= BK_IDLE;
            end
         endcase
      end
   end

   // two-entry output buffer, inverted bytes as sent to the panel
   always_ff @(posedge clock) begin
      if (inflight_ff) begin
         oq_data_ff[tail] <= ~rd_data_ff;
         oq_last_ff[tail] <= rd_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= 1'b0;
         oq_head_ff  <= 1'b0;
         occ_ff      <= 2'd0;
      end else begin
         inflight_ff <= issue;
         oq_head_ff  <= oq_head_ff ^ pop;
         occ_ff      <= occ_ff + {1'b0, inflight_ff} - {1'b0, pop};
      end
   end

   assign rsp.valid      = (occ_ff != 2'd0);
   assign rsp.pixel_byte = oq_data_ff[oq_head_ff];
   assign rsp.last       = oq_last_ff[oq_head_ff];

`ifndef SYNTHESIS
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= 2'd2)
      else $error("output buffer overflow");

   a_inflight_room: assert property (@(posedge clock) disable iff (reset)
      inflight_ff |-> occ_ff <= 2'd1)
      else $error("read returned with no room in output buffer");

   a_read_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_READ |-> left_ff != '0)
      else $error("row readout running with no bytes left");

   a_job_taken: assert property (@(posedge clock) disable iff (reset)
      (job_valid && job_ready) |=> state_ff != BK_IDLE)
      else $error("accepted job not started");
`endif

endmodule

// ===== hdl/rotated_framebuffer_pixel_engine.sv =====
// top level of the rotated 1-bit framebuffer pixel engine
//
//   channel   direction  handshake            payload
//   req_ch    in         valid / ready        cmd, x, y, color, window_width,
//                                             window_height, row_offset
//   rsp_ch    out        valid / ready        pixel_byte, last
//   apb       in         psel/penable/pready  rotation register at byte 0
//
// the front end takes each item through idle, map and address states, overlapped with the back
// (a dropped item skips the address state); draw: a store read then a write back; fill: every
// store byte in turn; read row: one store byte a cycle while the output buffer has room
// a two-job queue and a two-byte output buffer let front and back stall apart
// synchronous reset clears control state; the store holds garbage until filled
module rotated_framebuffer_pixel_engine #(
   parameter int PANEL_WIDTH  = rfpe_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = rfpe_pkg::DEF_PANEL_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   rfpe_req_if.sink                       req_ch,
   rfpe_rsp_if.source                     rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rfpe_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   logic [1:0]        rotation_ff;
   logic              sel_rotation;
   logic              fr_job_valid, fr_job_ready;
   rfpe_pkg::job_type fr_job;
   logic              bk_job_valid, bk_job_ready;
   rfpe_pkg::job_type bk_job;

   assign pready       = 1'b1;
   assign sel_rotation = (paddr[rfpe_pkg::CSR_ADDR_W-1:2] == rfpe_pkg::REG_ROTATION);
   assign prdata       = sel_rotation ? {30'b0, rotation_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= 2'd0;
      end else if (psel && penable && pwrite && pready && sel_rotation) begin
         rotation_ff <= pwdata[1:0];
      end
   end

   rfpe_front #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .rotation  (rotation_ff),
      .req       (req_ch),
      .job_valid (fr_job_valid),
      .job_ready (fr_job_ready),
      .job       (fr_job)
   );

   rfpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_job_valid),
      .in_ready  (fr_job_ready),
      .in_job    (fr_job),
      .out_valid (bk_job_valid),
      .out_ready (bk_job_ready),
      .out_job   (bk_job)
   );

   rfpe_back #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (bk_job_valid),
      .job_ready (bk_job_ready),
      .job       (bk_job),
      .rsp       (rsp_ch)
   );

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the rotated framebuffer pixel engine
module tb;

   localparam int PANEL_W = rfpe_pkg::DEF_PANEL_WIDTH;
   localparam int PANEL_H = rfpe_pkg::DEF_PANEL_HEIGHT;
   localparam int ROW_BYTES = (PANEL_W + 7) / 8;
   localparam int STORE_BYTES = ROW_BYTES * PANEL_H;
   localparam int SETTLE_CYCLES = STORE_BYTES + 200;
   localparam int HOLD_CYCLES = 400;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int TIMEOUT_CYCLES = 2_000_000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [rfpe_pkg::CSR_ADDR_W-1:0] ROTATION_ADDR = {rfpe_pkg::REG_ROTATION, 2'b00};

   typedef struct packed {
      logic [1:0]        cmd;
      logic signed [9:0] x;
      logic signed [9:0] y;
      logic              color;
      logic [8:0]        window_width;
      logic [8:0]        window_height;
      logic [8:0]        row_offset;
   } pixel_job_type;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       last;
   } row_byte_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [rfpe_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   rfpe_req_if req_if ();
   rfpe_rsp_if rsp_if ();

   rotated_framebuffer_pixel_engine dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   pixel_job_type          queued_jobs [$];
   row_byte_type           row_bytes_due [$];
   logic [7:0]             pixel_store [STORE_BYTES];
   rfpe_pkg::rotation_type rotation_now;
   rfpe_pkg::rotation_type rotation_plan [8] = '{
      rfpe_pkg::ROT_0, rfpe_pkg::ROT_270, rfpe_pkg::ROT_90, rfpe_pkg::ROT_180,
      rfpe_pkg::ROT_270, rfpe_pkg::ROT_0, rfpe_pkg::ROT_180, rfpe_pkg::ROT_90};
   logic job_taken;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   hold_asked;
   int   hold_given;
   int   hold_left;
   int   errors;
   int   bytes_checked;
   int   cmd_count [4];

   always #5 clock = ~clock;

   function automatic void apply_command(input pixel_job_type job);
      int col, row, lw, lh, px, py, span, room, rows_left, count, idx;
      logic [7:0] stored;
      col = int'($signed(job.x));
      row = int'($signed(job.y));
      case (job.cmd)
         rfpe_pkg::CMD_DRAW: begin
            lw = (rotation_now == rfpe_pkg::ROT_90 || rotation_now == rfpe_pkg::ROT_270) ?
                 PANEL_H : PANEL_W;
            lh = (rotation_now == rfpe_pkg::ROT_90 || rotation_now == rfpe_pkg::ROT_270) ?
                 PANEL_W : PANEL_H;
            if (col >= 0 && col < lw && row >= 0 && row < lh) begin
               case (rotation_now)
                  rfpe_pkg::ROT_90: begin
                     px = PANEL_W - 1 - row;
                     py = col;
                  end
                  rfpe_pkg::ROT_180: begin
                     px = PANEL_W - 1 - col;
                     py = PANEL_H - 1 - row;
                  end
                  rfpe_pkg::ROT_270: begin
                     px = row;
                     py = PANEL_H - 1 - col;
                  end
                  default: begin
                     px = col;
                     py = row;
                  end
               endcase
               idx = py * ROW_BYTES + px / 8;
               if (idx < STORE_BYTES)
                  pixel_store[idx][7 - px % 8] = ~job.color;
            end
         end
         rfpe_pkg::CMD_FILL: begin
            foreach (pixel_store[i])
               pixel_store[i] = job.color ? rfpe_pkg::FILL_BLACK : rfpe_pkg::FILL_WHITE;
         end
         rfpe_pkg::CMD_READ: begin
            if (col >= 0 && col < PANEL_W && row >= 0 && row < PANEL_H) begin
               span = int'(job.window_width) + 7;
               room = PANEL_W - col;
               if (span > room)
                  span = room;
               span += col % 8;
               rows_left = PANEL_H - row;
               if (int'(job.window_height) < rows_left)
                  rows_left = int'(job.window_height);
               if (int'(job.row_offset) < rows_left) begin
                  count = span / 8;
                  for (int k = 0; k < count; k++) begin
                     idx = (row + int'(job.row_offset)) * ROW_BYTES + col / 8 + k;
                     stored = (idx < STORE_BYTES) ? pixel_store[idx] : 8'h00;
                     row_bytes_due.push_back('{~stored, k == count - 1});
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic pixel_job_type make_job(input logic [1:0] cmd, input int x, input int y,
                                              input logic color, input int ww, input int wh,
                                              input int roff);
      pixel_job_type job;
      job.cmd = cmd;
      job.x = 10'(x);
      job.y = 10'(y);
      job.color = color;
      job.window_width = 9'(ww);
      job.window_height = 9'(wh);
      job.row_offset = 9'(roff);
      return job;
   endfunction

   // mostly well-formed draws and reads, some with raw field values, plus fills and unused commands
   function automatic pixel_job_type random_job(input rfpe_pkg::rotation_type rot);
      pixel_job_type job;
      int pick, lw, lh;
      job.cmd = rfpe_pkg::CMD_DRAW;
      job.x = 10'($urandom);
      job.y = 10'($urandom);
      job.color = 1'($urandom);
      job.window_width = 9'($urandom);
      job.window_height = 9'($urandom);
      job.row_offset = 9'($urandom);
      lw = (rot == rfpe_pkg::ROT_90 || rot == rfpe_pkg::ROT_270) ? PANEL_H : PANEL_W;
      lh = (rot == rfpe_pkg::ROT_90 || rot == rfpe_pkg::ROT_270) ? PANEL_W : PANEL_H;
      pick = $urandom_range(99);
      if (pick < 3) begin
         job.cmd = rfpe_pkg::CMD_FILL;
      end else if (pick < 5) begin
         job.cmd = CMD_UNUSED;
      end else if (pick < 50) begin
         if ($urandom_range(99) >= 15) begin
            job.x = 10'($urandom_range(lw - 1));
            job.y = 10'($urandom_range(lh - 1));
         end
      end else begin
         job.cmd = rfpe_pkg::CMD_READ;
         if ($urandom_range(99) >= 15) begin
            job.x = 10'($urandom_range(PANEL_W - 1));
            job.y = 10'($urandom_range(PANEL_H - 1));
            if ($urandom_range(3) != 0)
               job.window_width = 9'($urandom_range(PANEL_W));
            job.window_height = 9'($urandom_range(300, 1));
            job.row_offset = 9'($urandom_range(int'(job.window_height) - 1));
         end
      end
      return job;
   endfunction

   task automatic set_rotation(input rfpe_pkg::rotation_type value);
      logic [31:0] readback;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ROTATION_ADDR;
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      rotation_now = value;
      if (readback !== 32'(value)) begin
         errors++;
         $display("%0t: rotation readback expected %h got %h", $time, 32'(value), readback);
      end
   endtask

   task automatic wait_until_idle();
      while (queued_jobs.size() != 0 || req_if.valid || row_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      pixel_job_type next_job;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || job_taken) begin
         if (queued_jobs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_job = queued_jobs.pop_front();
            req_if.cmd <= next_job.cmd;
            req_if.x <= next_job.x;
            req_if.y <= next_job.y;
            req_if.color <= next_job.color;
            req_if.window_width <= next_job.window_width;
            req_if.window_height <= next_job.window_height;
            req_if.row_offset <= next_job.row_offset;
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_given) begin
         hold_given <= hold_asked;
         hold_left <= HOLD_CYCLES;
      end
   end

   always @(negedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      row_byte_type  want;
      pixel_job_type taken;
      job_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (row_bytes_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none got pixel_byte %h last %b",
                     $time, rsp_if.pixel_byte, rsp_if.last);
         end else begin
            want = row_bytes_due.pop_front();
            bytes_checked++;
            if (rsp_if.pixel_byte !== want.pixel_byte) begin
               errors++;
               $display("%0t: pixel_byte expected %h got %h",
                        $time, want.pixel_byte, rsp_if.pixel_byte);
            end
            if (rsp_if.last !== want.last) begin
               errors++;
               $display("%0t: last expected %b got %b", $time, want.last, rsp_if.last);
            end
         end
      end
      if (!reset && req_if.valid && req_if.ready) begin
         taken = '{req_if.cmd, req_if.x, req_if.y, req_if.color, req_if.window_width,
                   req_if.window_height, req_if.row_offset};
         cmd_count[taken.cmd]++;
         apply_command(taken);
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("%0t: timed out with %0d bytes still expected", $time, row_bytes_due.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int lw, lh, counted;
      pixel_job_type job;
      clock = 1'b0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_if.valid = 1'b0;
      req_if.cmd = rfpe_pkg::CMD_DRAW;
      req_if.x = '0;
      req_if.y = '0;
      req_if.color = 1'b0;
      req_if.window_width = '0;
      req_if.window_height = '0;
      req_if.row_offset = '0;
      rsp_if.ready = 1'b0;
      job_taken = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_asked = 0;
      hold_given = 0;
      hold_left = 0;
      errors = 0;
      bytes_checked = 0;
      cmd_count = '{default: 0};
      rotation_now = rfpe_pkg::ROT_0;
      foreach (pixel_store[i])
         pixel_store[i] = 8'h00;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: corners, clipping, empty windows, unused command
      set_rotation(rfpe_pkg::ROT_0);
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_FILL, 0, 0, 1'b0, 0, 0, 0));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_DRAW, 0, 0, 1'b1, 0, 0, 0));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_DRAW, PANEL_W - 1, PANEL_H - 1, 1'b1,
                                     0, 0, 0));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_DRAW, -512, 5, 1'b1, 0, 0, 0));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_DRAW, PANEL_W, 0, 1'b1, 0, 0, 0));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_DRAW, 511, 511, 1'b1, 511, 511, 511));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_READ, 0, 0, 1'b0, 511, 511, 0));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_READ, 0, 0, 1'b1, 511, 511, PANEL_H - 1));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_READ, -1, 0, 1'b0, 511, 511, 0));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_READ, PANEL_W, 0, 1'b0, 511, 511, 0));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_READ, 0, -512, 1'b0, 511, 511, 0));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_READ, 0, 0, 1'b0, 0, 511, 0));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_READ, PANEL_W - 1, PANEL_H - 1, 1'b0,
                                     0, 511, 0));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_READ, 0, 0, 1'b0, 511, 0, 0));
      queued_jobs.push_back(make_job(rfpe_pkg::CMD_READ, 8, PANEL_H - 4, 1'b0, 1, 10, 4));
      queued_jobs.push_back(make_job(CMD_UNUSED, 3, 3, 1'b1, 8, 8, 0));
      wait_until_idle();
      for (int r = 1; r < 4; r++) begin
         set_rotation(rfpe_pkg::rotation_type'(r));
         lw = (r % 2 == 1) ? PANEL_H : PANEL_W;
         lh = (r % 2 == 1) ? PANEL_W : PANEL_H;
         if (r == 3)
            queued_jobs.push_back(make_job(rfpe_pkg::CMD_FILL, 0, 0, 1'b1, 0, 0, 0));
         queued_jobs.push_back(make_job(rfpe_pkg::CMD_DRAW, 0, 0, r == 3 ? 1'b0 : 1'b1,
                                        0, 0, 0));
         queued_jobs.push_back(make_job(rfpe_pkg::CMD_DRAW, lw - 1, lh - 1,
                                        r == 3 ? 1'b0 : 1'b1, 0, 0, 0));
         queued_jobs.push_back(make_job(rfpe_pkg::CMD_READ, 0, 0, 1'b0, 511, 1, 0));
         wait_until_idle();
      end

      // random phases over idling modes and rotations
      for (int phase = 0; phase < 8; phase++) begin
         send_idle_pct = (phase % 4 == 1) ? 48 : (phase % 4 == 3) ? 33 : 0;
         recv_stall_pct = (phase % 4 == 2) ? 48 : (phase % 4 == 3) ? 33 : 0;
         set_rotation(rotation_plan[phase]);
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            job = random_job(rotation_plan[phase]);
            queued_jobs.push_back(job);
            if (job.cmd != CMD_UNUSED)
               counted++;
         end
         if (phase % 4 == 0)
            hold_asked++;
         wait_until_idle();
      end

      $display("covered %0d draws, %0d fills, %0d row reads and %0d unused commands",
               cmd_count[rfpe_pkg::CMD_DRAW], cmd_count[rfpe_pkg::CMD_FILL],
               cmd_count[rfpe_pkg::CMD_READ], cmd_count[CMD_UNUSED]);
      $display("checked %0d row bytes over all four rotations, with idling and hold-offs",
               bytes_checked);
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
